// ===== rtl/tqs_pkg.sv =====
// Shared types and codes for the tone queue sequencer.
package tqs_pkg;

   localparam int FUNC_W     = 2;
   localparam int PITCH_W    = 8;
   localparam int HAPTIC_W   = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 8;

   // item function codes
   localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_ENQ   = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_PLAY  = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SOUND_LEVEL     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SPEAKER_MODE    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PITCH_TRIM      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_HAPTIC_STRENGTH = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PITCH_OFFSET    = 3'd4;

   // sound level codes
   localparam logic [2:0] SL_MUTE   = 3'd0;
   localparam logic [2:0] SL_XSHORT = 3'd2;
   localparam logic [2:0] SL_SHORT  = 3'd3;
   localparam logic [2:0] SL_LONG   = 3'd5;
   localparam logic [2:0] SL_XLONG  = 3'd6;
   localparam logic [2:0] SL_RESET  = 3'd4;

   // speaker modes
   localparam logic [1:0] SPK_PLAIN  = 2'd0;
   localparam logic [1:0] SPK_SQUARE = 2'd1;

   localparam logic [HAPTIC_W-1:0] HAPTIC_PULSE = 2'd1;

   localparam int SQUARE_BIT = 7;

   typedef struct packed {
      logic [PITCH_W-1:0]  start_pitch;
      logic [PITCH_W-1:0]  end_pitch;
      logic [PITCH_W-1:0]  tone_length;
      logic [PITCH_W-1:0]  pause_length;
      logic [PITCH_W-1:0]  repeat_count;
      logic [HAPTIC_W-1:0] haptic_mode;
   } slot_type;

   typedef struct packed {
      logic buzzer_level;
      logic haptic_level;
      logic busy_res;
      logic dropped;
   } res_type;

   typedef struct packed {
      logic              exec;
      logic [FUNC_W-1:0] op;
      logic              cfg_we;
   } cmd_type;

endpackage

// ===== rtl/tqs_ifs.sv =====
// Channel interfaces for the tone queue sequencer.
interface tqs_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] func;
   logic [7:0] start_pitch;
   logic [7:0] end_pitch;
   logic [7:0] tone_length;
   logic [7:0] pause_length;
   logic [7:0] repeat_count;
   logic [1:0] haptic_mode;
   modport source (output valid, func, start_pitch, end_pitch, tone_length, pause_length,
                   repeat_count, haptic_mode, input ready);
   modport sink (input valid, func, start_pitch, end_pitch, tone_length, pause_length,
                 repeat_count, haptic_mode, output ready);
endinterface

interface tqs_rsp_if;
   logic valid;
   logic ready;
   logic buzzer_level;
   logic haptic_level;
   logic busy_res;
   logic dropped;
   modport source (output valid, buzzer_level, haptic_level, busy_res, dropped,
                   input ready);
   modport sink (input valid, buzzer_level, haptic_level, busy_res, dropped,
                 output ready);
endinterface

interface tqs_csr_if;
   logic       valid;
   logic       ready;
   logic [2:0] index;
   logic [7:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/tqs_ctrl.sv =====
// Handshake controller: accepts items, tracks the result register, issues commands.
module tqs_ctrl
   import tqs_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic [FUNC_W-1:0] req_func,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  logic              csr_valid,
   output logic              csr_ready,
   output cmd_type           cmd
);

   localparam logic ST_EMPTY = 1'b0;
   localparam logic ST_FULL  = 1'b1;

   logic state_ff, state_in;
   logic accept;

   assign req_ready = (state_ff == ST_EMPTY) || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = (state_ff == ST_FULL);
   assign csr_ready = 1'b1;

   always_comb begin
      case (state_ff)
         ST_EMPTY: state_in = accept ? ST_FULL : ST_EMPTY;
         ST_FULL:  state_in = (accept || !rsp_ready) ? ST_FULL : ST_EMPTY;
         default:  state_in = ST_EMPTY;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_EMPTY;
      end else begin
         state_ff <= state_in;
      end
   end

   assign cmd.exec   = accept;
   assign cmd.op     = req_func;
   assign cmd.cfg_we = csr_valid && csr_ready;

endmodule

// ===== rtl/tqs_dpath.sv =====
// Datapath: config registers, tone queue, tone/sweep/haptic state, result register.
module tqs_dpath
   import tqs_pkg::*;
#(
   parameter int QUEUE_DEPTH = 8,
   parameter int DIV_XSHORT  = 1,
   parameter int DIV_SHORT   = 2,
   parameter int DIV_NORM    = 3,
   parameter int DIV_LONG    = 4,
   parameter int DIV_XLONG   = 5
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   input  slot_type              req_item,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output res_type               res
);

   // config
   logic [2:0] sound_level_ff;
   logic [1:0] speaker_mode_ff;
   logic [7:0] pitch_trim_ff, haptic_strength_ff, pitch_offset_ff;

   // queue and tone state
   slot_type q_ff [QUEUE_DEPTH];
   slot_type q_in [QUEUE_DEPTH];
   logic [7:0] cp_ff, cp_in, tl_ff, tl_in, pl_ff, pl_in;
   logic       playing_ff, playing_in, sweep_on_ff, sweep_on_in, sweep_up_ff, sweep_up_in;
   logic       ra_ff, ra_in;
   logic [7:0] rl_ff, rl_in;
   logic [HAPTIC_W-1:0] hot_ff, hot_in;
   logic [7:0] hc_ff, hc_in, dc_ff, dc_in, acc_ff, acc_in;
   logic       buz_ff, buz_in, hap_ff, hap_in;
   logic       drop;
   res_type    res_ff;

   logic [7:0] div_lim;
   slot_type   head;
   logic       load;

   assign head = q_ff[0];
   assign load = ((head.start_pitch != '0) || (head.haptic_mode == HAPTIC_PULSE)) &&
                 (tl_ff == '0) && !playing_ff;

   always_comb begin
      case (sound_level_ff)
         SL_XSHORT: div_lim = 8'(DIV_XSHORT);
         SL_SHORT:  div_lim = 8'(DIV_SHORT);
         SL_LONG:   div_lim = 8'(DIV_LONG);
         SL_XLONG:  div_lim = 8'(DIV_XLONG);
         default:   div_lim = 8'(DIV_NORM);
      endcase
   end

   always_comb begin
      logic       found;
      logic       shift;
      logic [7:0] dc_sum;
      found       = 1'b0;
      shift       = 1'b0;
      dc_sum      = dc_ff + 8'd1;
      q_in        = q_ff;
      cp_in       = cp_ff;
      tl_in       = tl_ff;
      pl_in       = pl_ff;
      playing_in  = playing_ff;
      sweep_on_in = sweep_on_ff;
      sweep_up_in = sweep_up_ff;
      ra_in       = ra_ff;
      rl_in       = rl_ff;
      hot_in      = hot_ff;
      hc_in       = hc_ff;
      dc_in       = dc_ff;
      acc_in      = acc_ff;
      buz_in      = buz_ff;
      hap_in      = hap_ff;
      drop        = 1'b0;
      case (cmd.op)
         FUNC_TICK: begin
            // output drive for this heartbeat
            if (playing_ff) begin
               if (sound_level_ff != SL_MUTE) begin
                  if (speaker_mode_ff == SPK_PLAIN) begin
                     buz_in = (tl_ff != '0);
                  end else if (speaker_mode_ff == SPK_SQUARE) begin
                     if (tl_ff != '0) begin
                        acc_in = acc_ff + cp_ff;
                        buz_in = acc_in[SQUARE_BIT];
                     end else begin
                        buz_in = 1'b0;
                     end
                  end
               end
               if ((hot_ff == HAPTIC_PULSE) && (haptic_strength_ff != '0) &&
                   (hc_ff < haptic_strength_ff)) begin
                  hap_in = 1'b1;
                  hc_in  = hc_ff + 8'd1;
               end else begin
                  if (hot_ff == HAPTIC_PULSE) hc_in = '0;
                  hap_in = 1'b0;
               end
            end else begin
               buz_in = 1'b0;
               hap_in = 1'b0;
            end
            // load queue head
            if (load) begin
               cp_in = (head.start_pitch != '0) ?
                       head.start_pitch + pitch_trim_ff + pitch_offset_ff : '0;
               if ((head.end_pitch != '0) && (head.end_pitch != head.start_pitch)) begin
                  sweep_up_in = head.end_pitch > head.start_pitch;
                  tl_in       = sweep_up_in ? head.end_pitch - head.start_pitch
                                            : head.start_pitch - head.end_pitch;
                  sweep_on_in = 1'b1;
               end else begin
                  sweep_up_in = 1'b0;
                  sweep_on_in = 1'b0;
                  tl_in       = head.tone_length;
               end
               pl_in      = head.pause_length;
               hot_in     = head.haptic_mode;
               playing_in = 1'b1;
               if ((head.repeat_count != '0) && !ra_ff) begin
                  ra_in = 1'b1;
                  rl_in = head.repeat_count;
               end
               if (ra_in) begin
                  rl_in = rl_in - 8'd1;
                  if (rl_in == '0) begin
                     ra_in = 1'b0;
                     shift = 1'b1;
                  end
               end else begin
                  shift = 1'b1;
               end
               if (shift) begin
                  for (int i = 0; i < QUEUE_DEPTH - 1; i++) q_in[i] = q_ff[i+1];
                  q_in[QUEUE_DEPTH-1] = '0;
               end
            end
            // heartbeat divider
            if (dc_sum >= div_lim) begin
               dc_in = '0;
               if ((tl_in != '0) && playing_in) begin
                  if (sweep_on_in) cp_in = sweep_up_in ? cp_in + 8'd1 : cp_in - 8'd1;
                  tl_in = tl_in - 8'd1;
               end
               if ((tl_in == '0) && playing_in) begin
                  if (pl_in == '0) playing_in = 1'b0;
                  else pl_in = pl_in - 8'd1;
               end
            end else begin
               dc_in = dc_sum;
            end
         end
         FUNC_ENQ: begin
            for (int i = 0; i < QUEUE_DEPTH; i++) begin
               if (!found && (q_ff[i].start_pitch == '0)) begin
                  q_in[i] = req_item;
                  found   = 1'b1;
               end
            end
            drop = !found;
         end
         FUNC_PLAY: begin
            for (int i = 1; i < QUEUE_DEPTH; i++) q_in[i] = '0;
            q_in[0]     = req_item;
            sweep_on_in = 1'b0;
            hot_in      = '0;
         end
         FUNC_CLEAR: begin
            for (int i = 0; i < QUEUE_DEPTH; i++) q_in[i] = '0;
            cp_in       = '0;
            tl_in       = '0;
            pl_in       = '0;
            playing_in  = 1'b0;
            sweep_on_in = 1'b0;
            sweep_up_in = 1'b0;
            ra_in       = 1'b0;
            rl_in       = '0;
            hot_in      = '0;
            hc_in       = '0;
            dc_in       = '0;
            acc_in      = '0;
            buz_in      = 1'b0;
            hap_in      = 1'b0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < QUEUE_DEPTH; i++) q_ff[i] <= '0;
         cp_ff       <= '0;
         tl_ff       <= '0;
         pl_ff       <= '0;
         playing_ff  <= 1'b0;
         sweep_on_ff <= 1'b0;
         sweep_up_ff <= 1'b0;
         ra_ff       <= 1'b0;
         rl_ff       <= '0;
         hot_ff      <= '0;
         hc_ff       <= '0;
         dc_ff       <= '0;
         acc_ff      <= '0;
         buz_ff      <= 1'b0;
         hap_ff      <= 1'b0;
      end else if (cmd.exec) begin
         q_ff        <= q_in;
         cp_ff       <= cp_in;
         tl_ff       <= tl_in;
         pl_ff       <= pl_in;
         playing_ff  <= playing_in;
         sweep_on_ff <= sweep_on_in;
         sweep_up_ff <= sweep_up_in;
         ra_ff       <= ra_in;
         rl_ff       <= rl_in;
         hot_ff      <= hot_in;
         hc_ff       <= hc_in;
         dc_ff       <= dc_in;
         acc_ff      <= acc_in;
         buz_ff      <= buz_in;
         hap_ff      <= hap_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sound_level_ff     <= SL_RESET;
         speaker_mode_ff    <= SPK_PLAIN;
         pitch_trim_ff      <= '0;
         haptic_strength_ff <= '0;
         pitch_offset_ff    <= '0;
      end else if (cmd.cfg_we) begin
         case (csr_index)
            CSR_SOUND_LEVEL:     sound_level_ff     <= csr_data[2:0];
            CSR_SPEAKER_MODE:    speaker_mode_ff    <= csr_data[1:0];
            CSR_PITCH_TRIM:      pitch_trim_ff      <= csr_data;
            CSR_HAPTIC_STRENGTH: haptic_strength_ff <= csr_data;
            CSR_PITCH_OFFSET:    pitch_offset_ff    <= csr_data;
            default: ;
         endcase
      end
   end

   // result register, no reset needed
   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         res_ff.buzzer_level <= buz_in;
         res_ff.haptic_level <= hap_in;
         res_ff.busy_res     <= (tl_in != '0);
         res_ff.dropped      <= drop;
      end
   end

   assign res = res_ff;

endmodule

// ===== rtl/tone_queue_sequencer.sv =====
// Top level of the beeper and haptic tone sequencer.
//
//  channel | dir | handshake     | carries
//  --------+-----+---------------+-----------------------------------------------
//  req_ch  | in  | valid / ready | func, tone fields (start/end pitch, lengths..)
//  rsp_ch  | out | valid / ready | buzzer_level, haptic_level, busy_res, dropped
//  csr_ch  | in  | valid / ready | index (0..4), 8-bit data; ready is always high
//
//  Every item (tick, enqueue, play now, clear) is done in the cycle it is accepted;
//  its result sits in a one-deep output register from the next cycle on.
//  Sustained rate is one item per cycle: a new item is taken in the same cycle
//  the waiting result is taken. When the result is stalled, req_ch.ready drops.
//  Reset is synchronous: queue, tone state and result register empty, registers
//  back to defaults (sound level 4, all others 0). No clearing pass.
module tone_queue_sequencer
   import tqs_pkg::*;
#(
   parameter int QUEUE_DEPTH = 8,
   parameter int DIV_XSHORT  = 1,
   parameter int DIV_SHORT   = 2,
   parameter int DIV_NORM    = 3,
   parameter int DIV_LONG    = 4,
   parameter int DIV_XLONG   = 5
) (
   input logic          clock,
   input logic          reset,
   tqs_req_if.sink      req_ch,
   tqs_rsp_if.source    rsp_ch,
   tqs_csr_if.sink      csr_ch
);

   cmd_type  cmd;
   slot_type req_item;
   res_type  res;

   // the item's tone fields form one queue slot
   assign req_item.start_pitch  = req_ch.start_pitch;
   assign req_item.end_pitch    = req_ch.end_pitch;
   assign req_item.tone_length  = req_ch.tone_length;
   assign req_item.pause_length = req_ch.pause_length;
   assign req_item.repeat_count = req_ch.repeat_count;
   assign req_item.haptic_mode  = req_ch.haptic_mode;

   tqs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_func  (req_ch.func),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .csr_valid (csr_ch.valid),
      .csr_ready (csr_ch.ready),
      .cmd       (cmd)
   );

   tqs_dpath #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .DIV_XSHORT  (DIV_XSHORT),
      .DIV_SHORT   (DIV_SHORT),
      .DIV_NORM    (DIV_NORM),
      .DIV_LONG    (DIV_LONG),
      .DIV_XLONG   (DIV_XLONG)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_item  (req_item),
      .csr_index (csr_ch.index),
      .csr_data  (csr_ch.data),
      .res       (res)
   );

   // result register drives the response payload directly
   assign rsp_ch.buzzer_level = res.buzzer_level;
   assign rsp_ch.haptic_level = res.haptic_level;
   assign rsp_ch.busy_res     = res.busy_res;
   assign rsp_ch.dropped      = res.dropped;

endmodule

// ===== rtl/tqs_chk.sv =====
// Port-level checker for the tone queue sequencer, bound to the top level.
module tqs_chk
   import tqs_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic [FUNC_W-1:0] req_func,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic              rsp_buzzer_level,
   input logic              rsp_haptic_level,
   input logic              rsp_busy_res,
   input logic              rsp_dropped
);

   logic req_acc;
   assign req_acc = req_valid && req_ready;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_dropped) &&
      $stable(rsp_busy_res) && $stable(rsp_buzzer_level) && $stable(rsp_haptic_level))
      else $error("stalled result changed");

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> rsp_valid)
      else $error("accepted item gave no result");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_acc))
      else $error("result without an accepted item");

   a_drop_enq_only: assert property (@(posedge clock) disable iff (reset)
      req_acc && (req_func != FUNC_ENQ) |=> !rsp_dropped)
      else $error("drop reported for a non-enqueue item");

   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      req_acc && (req_func == FUNC_CLEAR) |=>
      !rsp_buzzer_level && !rsp_haptic_level && !rsp_busy_res && !rsp_dropped)
      else $error("clear left outputs active");

endmodule

bind tone_queue_sequencer tqs_chk u_tqs_chk (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_ch.valid),
   .req_ready        (req_ch.ready),
   .req_func         (req_ch.func),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_buzzer_level (rsp_ch.buzzer_level),
   .rsp_haptic_level (rsp_ch.haptic_level),
   .rsp_busy_res     (rsp_ch.busy_res),
   .rsp_dropped      (rsp_ch.dropped)
);
